FILE: sv/cbq_pkg.sv
// shared types and constants for the cascaded biquad filter
`timescale 1ns / 1ps

package cbq_pkg;

    // command codes carried on the command field
    localparam logic [1:0] CMD_FILTER = 2'd0;
    localparam logic [1:0] CMD_COEF   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_STAGE_COUNT = 2'd0;
    localparam logic [1:0] REG_INPUT_SCALE = 2'd1;
    localparam logic [1:0] REG_Q_FORMAT    = 2'd2;

    // coefficient slot within a stage
    localparam int COEFS_PER_STAGE = 5;
    localparam logic [2:0] K_A2 = 3'd0;
    localparam logic [2:0] K_A1 = 3'd1;
    localparam logic [2:0] K_B2 = 3'd2;
    localparam logic [2:0] K_B1 = 3'd3;
    localparam logic [2:0] K_B0 = 3'd4;

    // microprogram step addresses
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_PRE_MUL = 4'd0;
    localparam logic [STEP_W-1:0] STEP_PRE_X   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_S0      = 4'd2;
    localparam logic [STEP_W-1:0] STEP_S1      = 4'd3;
    localparam logic [STEP_W-1:0] STEP_S2      = 4'd4;
    localparam logic [STEP_W-1:0] STEP_S3      = 4'd5;
    localparam logic [STEP_W-1:0] STEP_S4      = 4'd6;
    localparam logic [STEP_W-1:0] STEP_S5      = 4'd7;
    localparam logic [STEP_W-1:0] STEP_S6      = 4'd8;
    localparam logic [STEP_W-1:0] STEP_S7      = 4'd9;
    localparam logic [STEP_W-1:0] STEP_S8      = 4'd10;
    localparam logic [STEP_W-1:0] STEP_OUT     = 4'd11;

    // multiplier operand selects
    typedef enum logic {
        A_COEF,
        A_SAMPLE
    } mula_t;

    typedef enum logic [2:0] {
        B_DLY,
        B_D0,
        B_D1,
        B_D2,
        B_SCALE
    } mulb_t;

    // accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    // special action of a step
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_X_IN,
        ACT_D0,
        ACT_LOOP,
        ACT_OUT
    } act_t;

    // one control word of the microprogram
    typedef struct packed {
        logic              coef_rd;
        logic [2:0]        coef_k;
        logic              dly_rd;
        logic              dly_wr;
        logic              dly_odd;
        logic              lat_d1;
        logic              lat_d2;
        logic              mul_en;
        mula_t             mul_a;
        mulb_t             mul_b;
        acc_op_t           acc_op;
        act_t              act;
        logic [STEP_W-1:0] jmp_to;
    } ucode_t;

endpackage

FILE: sv/cbq_ucode_rom.sv
// microprogram table: one control word per step
`timescale 1ns / 1ps

module cbq_ucode_rom (
    input  logic [cbq_pkg::STEP_W-1:0] pc,
    output cbq_pkg::ucode_t            word
);
    import cbq_pkg::*;

    always_comb
    begin
        word = '0;
        case (pc)
            // input scaling product
            STEP_PRE_MUL:
            begin
                word.mul_en = 1'b1;
                word.mul_a  = A_SAMPLE;
                word.mul_b  = B_SCALE;
            end
            // x takes the high word, stage loop starts
            STEP_PRE_X:
            begin
                word.act = ACT_X_IN;
            end
            // fetch d1 and a1
            STEP_S0:
            begin
                word.dly_rd  = 1'b1;
                word.dly_odd = 1'b0;
                word.coef_rd = 1'b1;
                word.coef_k  = K_A1;
            end
            // a1*d1, fetch d2 and a2
            STEP_S1:
            begin
                word.mul_en  = 1'b1;
                word.mul_a   = A_COEF;
                word.mul_b   = B_DLY;
                word.lat_d1  = 1'b1;
                word.dly_rd  = 1'b1;
                word.dly_odd = 1'b1;
                word.coef_rd = 1'b1;
                word.coef_k  = K_A2;
            end
            // a2*d2, fetch b0
            STEP_S2:
            begin
                word.mul_en  = 1'b1;
                word.mul_a   = A_COEF;
                word.mul_b   = B_DLY;
                word.lat_d2  = 1'b1;
                word.acc_op  = ACC_LOAD;
                word.coef_rd = 1'b1;
                word.coef_k  = K_B0;
            end
            // feedback sum complete
            STEP_S3:
            begin
                word.acc_op = ACC_ADD;
            end
            // new delay word
            STEP_S4:
            begin
                word.act = ACT_D0;
            end
            // b0*d0, old d1 moves to d2 slot, fetch b1
            STEP_S5:
            begin
                word.mul_en  = 1'b1;
                word.mul_a   = A_COEF;
                word.mul_b   = B_D0;
                word.dly_wr  = 1'b1;
                word.dly_odd = 1'b1;
                word.coef_rd = 1'b1;
                word.coef_k  = K_B1;
            end
            // b1*d1, d0 goes to d1 slot, fetch b2
            STEP_S6:
            begin
                word.mul_en  = 1'b1;
                word.mul_a   = A_COEF;
                word.mul_b   = B_D1;
                word.acc_op  = ACC_LOAD;
                word.dly_wr  = 1'b1;
                word.dly_odd = 1'b0;
                word.coef_rd = 1'b1;
                word.coef_k  = K_B2;
            end
            // b2*d2
            STEP_S7:
            begin
                word.mul_en = 1'b1;
                word.mul_a  = A_COEF;
                word.mul_b  = B_D2;
                word.acc_op = ACC_ADD;
            end
            // stage output, branch back unless last stage
            STEP_S8:
            begin
                word.act    = ACT_LOOP;
                word.jmp_to = STEP_S0;
            end
            // hand result to the output register
            STEP_OUT:
            begin
                word.act = ACT_OUT;
            end
            default:
            begin
                word = '0;
            end
        endcase
    end

endmodule

FILE: sv/cbq_coef_mem.sv
// coefficient memory, one write and one registered read port
`timescale 1ns / 1ps

module cbq_coef_mem #(
    parameter int DEPTH = 40,
    parameter int AW    = 6
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic signed [31:0]  wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic signed [31:0]  rd_data
);
    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, holds its word between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/cbq_dly_mem.sv
// delay word memory with per-entry valid bits, unwritten entries read as zero
`timescale 1ns / 1ps

module cbq_dly_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic signed [31:0]  wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic signed [31:0]  rd_data
);
    logic signed [31:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic signed [31:0] rd_data_reg;
    logic               rd_valid_reg;

    // valid bits: reset and clear command empty every entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // storage array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : 32'sd0;

endmodule

FILE: sv/cascaded_biquad_iir_q31.sv
// top level: cascaded direct-form-II biquad filter, Q31 samples
`timescale 1ns / 1ps

// Cascaded biquad IIR filter for signed 32-bit samples. Each input beat carries a
// command: filter a sample (one result beat), write one coefficient, or clear the
// delay words (no result). Coefficients and clears take effect in the cycle they are
// accepted. A sample is worked by a small microprogram around one shared 32x32
// multiplier and a 64-bit accumulator: input scaling steps, a run of steps per
// biquad stage (five products plus the delay update), and a step that loads the
// output register, stalling while that register still holds an unread result.
// The multiplier and the single read port of each memory set the program's length.
// The input side takes no new beat while a sample is being worked; a finished
// result waits in the output register while further beats are accepted. Coefficient
// slots read before being written return undefined data; delay words start at zero
// after reset.
module cascaded_biquad_iir_q31 #(
    parameter int MAX_STAGES = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic signed [31:0] sample,
    input  logic [5:0]         coef_index,
    input  logic signed [31:0] coef_value,
    // output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] filtered,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cbq_pkg::*;

    localparam int NUM_COEFS = COEFS_PER_STAGE * MAX_STAGES;
    localparam int NUM_DLY   = 2 * MAX_STAGES;
    localparam int CAW       = $clog2(NUM_COEFS);
    localparam int DAW       = $clog2(NUM_DLY);
    localparam int SW        = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

    // configuration registers
    logic [3:0]         stage_count_reg;
    logic signed [31:0] input_scale_reg;
    logic [4:0]         q_format_reg;

    // sequencer state
    logic               busy_reg;
    logic [STEP_W-1:0]  pc_reg;
    logic [SW-1:0]      stage_reg;
    logic [CAW-1:0]     coef_base_reg;
    ucode_t             uc;

    // datapath registers
    logic signed [31:0] sample_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] d0_reg;
    logic signed [31:0] d1_reg;
    logic signed [31:0] d2_reg;
    logic signed [63:0] prod_reg;
    logic [63:0]        acc_reg;
    logic signed [31:0] filtered_reg;
    logic               out_valid_reg;

    // handshake and decode
    logic               cfg_wr;
    logic               in_fire;
    logic               start;
    logic               coef_wr;
    logic               dly_clear;
    logic               out_load;
    logic               is_last;
    logic [3:0]         cnt_eff;
    logic [4:0]         q_eff;
    logic [4:0]         d0_shift;
    logic [4:0]         out_shift;
    logic [63:0]        acc_sum;
    logic [31:0]        w_sum;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [31:0] coef_q;
    logic signed [31:0] dly_q;
    logic [CAW-1:0]     coef_rd_addr;
    logic [DAW-1:0]     dly_addr;
    logic signed [31:0] dly_wdata;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_count_reg <= 4'd1;
            input_scale_reg <= 32'sh7FFF_FFFF;
            q_format_reg    <= 5'd30;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_STAGE_COUNT: stage_count_reg <= pwdata[3:0];
                REG_INPUT_SCALE: input_scale_reg <= pwdata;
                REG_Q_FORMAT:    q_format_reg    <= pwdata[4:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_STAGE_COUNT: prdata = {28'd0, stage_count_reg};
            REG_INPUT_SCALE: prdata = input_scale_reg;
            REG_Q_FORMAT:    prdata = {27'd0, q_format_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // input beat decode
    assign in_ready  = !busy_reg;
    assign in_fire   = in_valid && in_ready;
    assign start     = in_fire && (command == CMD_FILTER);
    assign coef_wr   = in_fire && (command == CMD_COEF) && (int'(coef_index) < NUM_COEFS);
    assign dly_clear = in_fire && (command == CMD_CLEAR);

    // effective stage count and shifts
    assign cnt_eff   = (stage_count_reg == 4'd0) ? 4'd1 : stage_count_reg;
    assign q_eff     = (q_format_reg == 5'd0) ? 5'd1 : q_format_reg;
    assign d0_shift  = 5'(6'd32 - {1'b0, q_eff});
    assign out_shift = 5'd31 - q_eff;
    assign is_last   = (int'(stage_reg) + 1 == int'(cnt_eff))
                    || (int'(stage_reg) + 1 == MAX_STAGES);

    // control word for the current step
    cbq_ucode_rom u_rom (
        .pc   (pc_reg),
        .word (uc)
    );

    // memories
    assign coef_rd_addr = coef_base_reg + CAW'(uc.coef_k);
    assign dly_addr     = DAW'({stage_reg, uc.dly_odd});
    assign dly_wdata    = uc.dly_odd ? d1_reg : d0_reg;

    cbq_coef_mem #(
        .DEPTH (NUM_COEFS),
        .AW    (CAW)
    ) u_coef_mem (
        .clk     (clk),
        .wr_en   (coef_wr),
        .wr_addr (CAW'(coef_index)),
        .wr_data (coef_value),
        .rd_en   (busy_reg && uc.coef_rd),
        .rd_addr (coef_rd_addr),
        .rd_data (coef_q)
    );

    cbq_dly_mem #(
        .DEPTH (NUM_DLY),
        .AW    (DAW)
    ) u_dly_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (dly_clear),
        .wr_en   (busy_reg && uc.dly_wr),
        .wr_addr (dly_addr),
        .wr_data (dly_wdata),
        .rd_en   (busy_reg && uc.dly_rd),
        .rd_addr (dly_addr),
        .rd_data (dly_q)
    );

    // output register loads when the slot is free
    assign out_load = busy_reg && (uc.act == ACT_OUT) && (!out_valid_reg || out_ready);

    // step counter and stage loop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= STEP_PRE_MUL;
            stage_reg     <= '0;
            coef_base_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);
            if (!busy_reg)
            begin
                if (start)
                begin
                    busy_reg <= 1'b1;
                    pc_reg   <= STEP_PRE_MUL;
                end
            end
            else
            begin
                case (uc.act)
                    ACT_X_IN:
                    begin
                        stage_reg     <= '0;
                        coef_base_reg <= '0;
                        pc_reg        <= pc_reg + 1'b1;
                    end
                    ACT_LOOP:
                    begin
                        if (is_last)
                        begin
                            pc_reg <= pc_reg + 1'b1;
                        end
                        else
                        begin
                            stage_reg     <= stage_reg + 1'b1;
                            coef_base_reg <= coef_base_reg + CAW'(COEFS_PER_STAGE);
                            pc_reg        <= uc.jmp_to;
                        end
                    end
                    ACT_OUT:
                    begin
                        if (out_load)
                        begin
                            busy_reg <= 1'b0;
                            pc_reg   <= STEP_PRE_MUL;
                        end
                    end
                    default:
                    begin
                        pc_reg <= pc_reg + 1'b1;
                    end
                endcase
            end
        end
    end

    // multiplier operand selection
    always_comb
    begin
        case (uc.mul_a)
            A_SAMPLE: op_a = sample_reg;
            default:  op_a = coef_q;
        endcase
        case (uc.mul_b)
            B_DLY:   op_b = dly_q;
            B_D0:    op_b = d0_reg;
            B_D1:    op_b = d1_reg;
            B_D2:    op_b = d2_reg;
            B_SCALE: op_b = input_scale_reg;
            default: op_b = dly_q;
        endcase
    end

    assign acc_sum = acc_reg + $unsigned(prod_reg);
    assign w_sum   = x_reg + acc_reg[63:32];

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sample_reg <= sample;
        end
        if (busy_reg)
        begin
            if (uc.mul_en)
            begin
                prod_reg <= op_a * op_b;
            end
            case (uc.acc_op)
                ACC_LOAD: acc_reg <= $unsigned(prod_reg);
                ACC_ADD:  acc_reg <= acc_sum;
                default:  ;
            endcase
            if (uc.lat_d1)
            begin
                d1_reg <= dly_q;
            end
            if (uc.lat_d2)
            begin
                d2_reg <= dly_q;
            end
            case (uc.act)
                ACT_X_IN: x_reg  <= prod_reg[63:32];
                ACT_D0:   d0_reg <= w_sum << d0_shift;
                ACT_LOOP: x_reg  <= acc_sum[63:32];
                default:  ;
            endcase
        end
        if (out_load)
        begin
            filtered_reg <= x_reg << out_shift;
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

    // a result appears only from the output step
    a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg && (pc_reg == STEP_OUT)))
        else $error("result raised outside the output step");

    // stage counter stays within the built stages
    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (int'(stage_reg) < MAX_STAGES))
        else $error("stage counter beyond built stages");

    // step counter stays inside the program
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= STEP_OUT))
        else $error("step counter outside program");

    // a filter beat starts the program at its first step
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (busy_reg && (pc_reg == STEP_PRE_MUL)))
        else $error("filter beat did not start the program");

endmodule

FILE: verif/tb_top.sv
// testbench for the cascaded biquad filter: predicted samples checked beat by beat
`timescale 1ns / 1ps

module tb_top;
    import cbq_pkg::*;

    localparam int STAGES_BUILT = 8;
    localparam int NUM_SLOTS = COEFS_PER_STAGE * STAGES_BUILT;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_BEATS = 230;
    localparam int unsigned TIMEOUT_NS = 10_000_000;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] smp;
        logic [5:0]  idx;
        logic [31:0] val;
    } beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] command = CMD_FILTER;
    logic signed [31:0] sample = '0;
    logic [5:0] coef_index = '0;
    logic signed [31:0] coef_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] filtered;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // filter state as the block should hold it
    logic signed [31:0] coef_mem [0:NUM_SLOTS-1];
    logic signed [31:0] dly_mem [0:2*STAGES_BUILT-1];
    logic [3:0] cfg_stages = 4'd1;
    logic signed [31:0] cfg_scale = 32'h7FFF_FFFF;
    logic [4:0] cfg_q = 5'd30;

    beat_t beats_to_send [$];
    logic [31:0] expected_filtered [$];
    int fail_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    cascaded_biquad_iir_q31 #(.MAX_STAGES(STAGES_BUILT)) uut (.*);

    always
    begin
        #2;
        clk = 1'b1;
        #2;
        clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void log_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%s", msg);
        end
    endfunction

    // exact product sign-extended so three of them sum without overflow
    function automatic logic signed [67:0] prod68(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return {{4{p[63]}}, p};
    endfunction

    // one sample through the scaler and every active stage
    function automatic logic [31:0] cascade_output(logic signed [31:0] smp);
        int n;
        int q;
        int c;
        logic signed [67:0] acc;
        logic signed [31:0] x;
        logic signed [31:0] w;
        logic signed [31:0] d0;
        logic signed [31:0] y;
        n = cfg_stages;
        if (n == 0)
            n = 1;
        if (n > STAGES_BUILT)
            n = STAGES_BUILT;
        q = cfg_q;
        if (q == 0)
            q = 1;
        acc = prod68(smp, cfg_scale);
        x = acc[63:32];
        y = '0;
        for (int s = 0; s < n; s++)
        begin
            c = COEFS_PER_STAGE * s;
            acc = prod68(coef_mem[c + K_A1], dly_mem[2*s])
                + prod68(coef_mem[c + K_A2], dly_mem[2*s+1]);
            w = x + acc[63:32];
            d0 = w << (32 - q);
            acc = prod68(coef_mem[c + K_B0], d0)
                + prod68(coef_mem[c + K_B1], dly_mem[2*s])
                + prod68(coef_mem[c + K_B2], dly_mem[2*s+1]);
            y = acc[63:32];
            dly_mem[2*s+1] = dly_mem[2*s];
            dly_mem[2*s] = d0;
            x = y;
        end
        return y << (31 - q);
    endfunction

    // apply one accepted input beat to the predicted state
    function automatic void absorb_beat(beat_t b);
        case (b.cmd)
            CMD_FILTER: expected_filtered.push_back(cascade_output(b.smp));
            CMD_COEF:
            begin
                if (b.idx < NUM_SLOTS)
                    coef_mem[b.idx] = b.val;
            end
            CMD_CLEAR:
            begin
                foreach (dly_mem[i])
                    dly_mem[i] = '0;
            end
            default: ; // unused code leaves everything alone
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3: ;
            4, 5: w = 32'($urandom_range(511)) - 32'd256;
            6:
            begin
                case ($urandom_range(4))
                    0: w = 32'h7FFF_FFFF;
                    1: w = 32'h8000_0000;
                    2: w = 32'h0;
                    3: w = 32'hFFFF_FFFF;
                    default: w = 32'h1;
                endcase
            end
            default: w = $signed(w) >>> $urandom_range(31);
        endcase
        return w;
    endfunction

    task automatic push_beat(logic [1:0] cmd, logic [31:0] smp, logic [5:0] idx,
                             logic [31:0] val);
        beat_t b;
        b.cmd = cmd;
        b.smp = smp;
        b.idx = idx;
        b.val = val;
        beats_to_send.push_back(b);
    endtask

    task automatic push_sample(logic [31:0] smp);
        push_beat(CMD_FILTER, smp, 6'($urandom), $urandom);
    endtask

    task automatic push_coef(logic [5:0] idx, logic [31:0] val);
        push_beat(CMD_COEF, $urandom, idx, val);
    endtask

    task automatic push_clear();
        push_beat(CMD_CLEAR, $urandom, 6'($urandom), $urandom);
    endtask

    // input beat driver: next beat goes out once the current one is taken
    always @(posedge clk)
    begin : input_driver
        beat_t seen;
        beat_t nxt;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                seen.cmd = command;
                seen.smp = sample;
                seen.idx = coef_index;
                seen.val = coef_value;
                absorb_beat(seen);
            end
            if (!in_valid || in_ready)
            begin
                if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = beats_to_send.pop_front();
                    in_valid <= 1'b1;
                    command <= nxt.cmd;
                    sample <= nxt.smp;
                    coef_index <= nxt.idx;
                    coef_value <= nxt.val;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output back-pressure
    always @(posedge clk)
    begin : result_monitor
        logic [31:0] want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_filtered.size() == 0)
                begin
                    log_failure($sformatf("result %h with none outstanding", filtered));
                end
                else
                begin
                    want = expected_filtered.pop_front();
                    if (filtered !== want)
                        log_failure($sformatf("filtered mismatch: expected %h got %h",
                                              want, filtered));
                end
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (holds_served != hold_requests)
            begin
                holds_served <= hold_requests;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic apb_write(logic [3:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read(logic [3:0] addr, output logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(logic [1:0] idx);
        logic [31:0] got;
        logic [31:0] want;
        case (idx)
            REG_STAGE_COUNT: want = {28'd0, cfg_stages};
            REG_INPUT_SCALE: want = cfg_scale;
            default: want = {27'd0, cfg_q};
        endcase
        apb_read({idx, 2'b00}, got);
        if (got !== want)
            log_failure($sformatf("register %0d readback: expected %h got %h", idx, want, got));
    endtask

    // write one register, sometimes with junk above its width
    task automatic set_register(logic [1:0] idx, logic [31:0] value);
        logic [31:0] wdata;
        wdata = value;
        if ($urandom_range(1))
        begin
            if (idx == REG_STAGE_COUNT)
                wdata[31:4] = 28'($urandom);
            else if (idx == REG_Q_FORMAT)
                wdata[31:5] = 27'($urandom);
        end
        apb_write({idx, 2'b00}, wdata);
        case (idx)
            REG_STAGE_COUNT: cfg_stages = wdata[3:0];
            REG_INPUT_SCALE: cfg_scale = wdata;
            REG_Q_FORMAT: cfg_q = wdata[4:0];
            default: ; // nothing lives at this address
        endcase
        if (idx != REG_UNMAPPED)
            check_register(idx);
    endtask

    task automatic apply_settings(logic [3:0] stages, logic [31:0] scale, logic [4:0] q);
        set_register(REG_STAGE_COUNT, {28'd0, stages});
        set_register(REG_INPUT_SCALE, scale);
        set_register(REG_Q_FORMAT, {27'd0, q});
    endtask

    task automatic set_idling(int unsigned snd, int unsigned rcv);
        @(posedge clk);
        send_idle_pct <= snd;
        recv_stall_pct <= rcv;
    endtask

    // everything sent, every result back, then let the pipeline settle
    // (checked mid-cycle so the driver's updates at the edge are visible)
    task automatic wait_drained();
        while (beats_to_send.size() != 0 || in_valid || expected_filtered.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // sample bursts with coefficient rewrites, clears and some noise
    task automatic push_random_traffic(int n_beats);
        int counted;
        int len;
        int kind;
        counted = 0;
        while (counted < n_beats)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                len = $urandom_range(16, 2);
                repeat (len) push_sample(rand_word());
                counted += len;
            end
            else if (kind < 85)
            begin
                len = $urandom_range(5, 1);
                repeat (len) push_coef(6'($urandom_range(NUM_SLOTS - 1)), rand_word());
                counted += len;
            end
            else if (kind < 92)
            begin
                push_clear();
                counted++;
            end
            else if (kind < 96)
            begin
                push_beat(CMD_UNUSED, $urandom, 6'($urandom), $urandom);
            end
            else
            begin
                push_coef(6'($urandom_range(63, NUM_SLOTS)), $urandom);
            end
        end
    endtask

    // stimulus and phase sequencing
    initial
    begin
        foreach (coef_mem[i])
            coef_mem[i] = '0;
        foreach (dly_mem[i])
            dly_mem[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers come out of reset at their defaults
        check_register(REG_STAGE_COUNT);
        check_register(REG_INPUT_SCALE);
        check_register(REG_Q_FORMAT);

        // directed: one stage, extreme coefficients and samples
        push_coef(6'(K_A2), 32'h8000_0000);
        push_coef(6'(K_A1), 32'h7FFF_FFFF);
        push_coef(6'(K_B2), 32'h4000_0000);
        push_coef(6'(K_B1), 32'hFFFF_FFFF);
        push_coef(6'(K_B0), 32'h7FFF_FFFF);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);
        push_sample(32'h0);
        push_sample(32'hFFFF_FFFF);
        push_sample(32'h1);
        // unused command and out-of-range slots are dropped
        push_beat(CMD_UNUSED, 32'h7FFF_FFFF, 6'd0, 32'h1234_5678);
        push_coef(6'(NUM_SLOTS), $urandom);
        push_coef(6'd63, $urandom);
        push_sample(32'h7FFF_FFFF);
        push_clear();
        push_sample(32'h8000_0000);
        push_coef(6'(K_B0), 32'h0);
        push_sample($urandom);
        push_clear();
        push_clear();
        push_sample($urandom);
        wait_drained();

        // fill every slot before more stages are enabled
        for (int i = 0; i < NUM_SLOTS; i++)
            push_coef(6'(i), rand_word());
        repeat (4) push_sample(rand_word());
        wait_drained();
        set_register(REG_UNMAPPED, $urandom);

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: apply_settings(4'd8, 32'h7FFF_FFFF, 5'd31);
                1: apply_settings(4'd15, 32'h8000_0000, 5'd1);
                2: apply_settings(4'd0, rand_word(), 5'd0);
                3: apply_settings(4'd3, 32'h0, 5'd16);
                4: apply_settings(4'($urandom_range(8, 1)), 32'hFFFF_FFFF,
                                  5'($urandom_range(31, 1)));
                5: apply_settings(4'd9, rand_word(), 5'd31);
                6: apply_settings(4'($urandom), rand_word(), 5'($urandom));
                default: apply_settings(4'd8, 32'h4000_0000, 5'd30);
            endcase
            case (p % 4)
                0: set_idling(0, 0);
                1: set_idling(84, 0);
                2: set_idling(0, 84);
                default: set_idling(23, 23);
            endcase
            // long output hold-off while the sender keeps offering
            if (p % 4 == 0)
            begin
                @(posedge clk);
                hold_requests <= hold_requests + 1;
            end
            push_random_traffic(PHASE_BEATS);
            wait_drained();
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
sv/cbq_pkg.sv
sv/cbq_ucode_rom.sv
sv/cbq_coef_mem.sv
sv/cbq_dly_mem.sv
sv/cascaded_biquad_iir_q31.sv
verif/tb_top.sv
